// ===== rtl/peer_learning_table_with_aging_assert.svh =====
// Assertion helpers for the peer table; the including module supplies clk and rst_n.
`ifndef PEER_LEARNING_TABLE_WITH_AGING_ASSERT_SVH
`define PEER_LEARNING_TABLE_WITH_AGING_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent.
`define PLTA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define PLTA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/plta_pkg.sv =====
package plta_pkg;

    localparam int ADDR_W    = 32;
    localparam int TIME_W    = 32;
    localparam int TIMEOUT_W = 16;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 4;
    localparam int COUNT_W   = 5;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30;

    localparam logic CMD_LEARN = 1'b0;
    localparam logic CMD_SWEEP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_REFRESH = 2'd0,
        STAT_INSERT  = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_SWEEP   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } seq_state_t;

    // Result of one pass through the shared compare unit
    typedef struct packed {
        logic match;
        logic stale;
    } cmp_res_t;

endpackage

// ===== rtl/peer_learning_table_with_aging.sv =====
// Peer learning table with aging.
// Input channel (in_valid/in_ready) carries one command beat: cmd 0 learns or
// refreshes peer_key with peer_addr, peer_name and now_seconds; cmd 1 sweeps
// out every entry older than stale_timeout seconds at now_seconds.
// Output channel (out_valid/out_ready) returns one beat per command: status,
// slot, removed_count and occupancy after the command.
// The user must write stale_timeout through cfg_wr_en/cfg_wr_data only while
// idle; the block itself does not enforce this. A command walks every entry
// through one shared compare unit, one entry per cycle, reading the entry store
// on its single read port. in_ready stays low from the input beat until the
// walk is done and the result is registered, so no new command is taken while
// one is still in the table.
// The result sits in an output register; a new command is accepted while it
// waits. If the receiver stalls, the next command finishes its walk and holds
// in its last step until the output register frees up.
// Reset clears all valid bits and the occupancy count and loads the timeout
// with 30; the entry store itself is not cleared and needs no clearing pass.
`include "peer_learning_table_with_aging_assert.svh"

module peer_learning_table_with_aging
    import plta_pkg::*;
#(
    parameter int ENTRIES   = 16,
    parameter int KEY_BITS  = 64,
    parameter int NAME_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [TIMEOUT_W-1:0] cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 cmd,
    input  logic [63:0]          peer_key,
    input  logic [ADDR_W-1:0]    peer_addr,
    input  logic [63:0]          peer_name,
    input  logic [TIME_W-1:0]    now_seconds,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [SLOT_W-1:0]    slot,
    output logic [COUNT_W-1:0]   removed_count,
    output logic [COUNT_W-1:0]   occupancy
);

    localparam int IW     = $clog2(ENTRIES);
    localparam int CW     = $clog2(ENTRIES + 1);
    localparam int WORD_W = TIME_W + KEY_BITS + ADDR_W + NAME_BITS;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    // Configuration
    logic [TIMEOUT_W-1:0] timeout_reg;

    // Sequencer and item registers
    seq_state_t           state_reg, state_next;
    logic                 cmd_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [NAME_BITS-1:0] name_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [IW-1:0]        iss_idx_reg, iss_idx_next;
    logic                 chk_vld_reg;
    logic [IW-1:0]        chk_idx_reg;

    // Scan results
    logic                 hit_found_reg, hit_found_next;
    logic [IW-1:0]        hit_idx_reg, hit_idx_next;
    logic                 free_found_reg, free_found_next;
    logic [IW-1:0]        free_idx_reg, free_idx_next;
    logic [CW-1:0]        removed_reg, removed_next;

    // Table state
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic [CW-1:0]        count_reg, count_next;

    // Output register
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [COUNT_W-1:0]   removed_out_reg;
    logic [COUNT_W-1:0]   occ_out_reg;

    // Control
    logic                 accept;
    logic                 scan_en;
    logic                 fin_go;
    logic                 ram_we;
    logic [IW-1:0]        tgt_idx;
    logic [WORD_W-1:0]    ram_wdata;
    logic [WORD_W-1:0]    ram_rdata;
    logic [TIME_W-1:0]    ent_seen;
    logic [KEY_BITS-1:0]  ent_key;
    cmp_res_t             cmp_res;

    assign accept = in_valid && in_ready;

    // Hold the timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (iss_idx_reg == LAST_IDX)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (fin_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        scan_en  = 1'b0;
        fin_go   = 1'b0;
        unique case (state_reg)
            S_IDLE:   in_ready = 1'b1;
            S_SCAN:   scan_en  = 1'b1;
            S_FINISH: fin_go   = !chk_vld_reg && (!out_valid_reg || out_ready);
            default:  in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Latch the item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            key_reg  <= peer_key[KEY_BITS-1:0];
            addr_reg <= peer_addr;
            name_reg <= peer_name[NAME_BITS-1:0];
            now_reg  <= now_seconds;
        end
    end

    // Entry store: {seen stamp, key, addr, name}
    assign ram_wdata = {now_reg, key_reg, addr_reg, name_reg};
    assign ent_seen  = ram_rdata[WORD_W-1 -: TIME_W];
    assign ent_key   = ram_rdata[WORD_W-TIME_W-1 -: KEY_BITS];
    assign tgt_idx   = hit_found_reg ? hit_idx_reg : free_idx_reg;
    assign ram_we    = fin_go && (cmd_reg == CMD_LEARN) && (hit_found_reg || free_found_reg);

    plta_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tgt_idx),
        .wdata (ram_wdata),
        .raddr (iss_idx_reg),
        .rdata (ram_rdata)
    );

    plta_cmp #(
        .KEY_BITS (KEY_BITS)
    ) u_cmp (
        .item_key  (key_reg),
        .entry_key (ent_key),
        .now       (now_reg),
        .seen      (ent_seen),
        .timeout   (timeout_reg),
        .res       (cmp_res)
    );

    // Advance the scan and fold in one checked entry per cycle
    always_comb
    begin
        iss_idx_next    = iss_idx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        removed_next    = removed_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;

        if (accept)
        begin
            iss_idx_next    = '0;
            hit_found_next  = 1'b0;
            hit_idx_next    = '0;
            free_found_next = 1'b0;
            free_idx_next   = '0;
            removed_next    = '0;
        end
        else if (scan_en)
        begin
            iss_idx_next = iss_idx_reg + 1'b1;
        end

        if (chk_vld_reg)
        begin
            if (cmd_reg == CMD_LEARN)
            begin
                if (valid_reg[chk_idx_reg])
                begin
                    if (cmp_res.match && !hit_found_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = chk_idx_reg;
                    end
                end
                else if (!free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = chk_idx_reg;
                end
            end
            else if (valid_reg[chk_idx_reg] && cmp_res.stale)
            begin
                valid_next[chk_idx_reg] = 1'b0;
                removed_next            = removed_reg + 1'b1;
                count_next              = count_reg - 1'b1;
            end
        end

        // Insert into the free slot
        if (ram_we && !hit_found_reg)
        begin
            valid_next[free_idx_reg] = 1'b1;
            count_next               = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            count_reg      <= '0;
            chk_vld_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            iss_idx_reg    <= '0;
        end
        else
        begin
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            chk_vld_reg    <= scan_en;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            iss_idx_reg    <= iss_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= iss_idx_reg;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        removed_reg  <= removed_next;
    end

    // Build the result beat
    always_comb
    begin
        status_next = STAT_FULL;
        slot_next   = '0;
        if (cmd_reg == CMD_SWEEP)
        begin
            status_next = STAT_SWEEP;
        end
        else if (hit_found_reg)
        begin
            status_next = STAT_REFRESH;
            slot_next   = SLOT_W'(hit_idx_reg);
        end
        else if (free_found_reg)
        begin
            status_next = STAT_INSERT;
            slot_next   = SLOT_W'(free_idx_reg);
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            status_reg      <= status_next;
            slot_reg        <= slot_next;
            removed_out_reg <= COUNT_W'(removed_reg);
            occ_out_reg     <= COUNT_W'(count_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign slot          = slot_reg;
    assign removed_count = removed_out_reg;
    assign occupancy     = occ_out_reg;

    `PLTA_ASSERT_SAME(a_count_matches_valid, 1'b1, count_reg == CW'($countones(valid_reg)), "occupancy count disagrees with valid bits")
    `PLTA_ASSERT_NEXT(a_accept_starts_scan, accept, state_reg == S_SCAN, "accepted beat did not start a scan")
    `PLTA_ASSERT_NEXT(a_learn_leaves_valid, ram_we, valid_reg[$past(tgt_idx)], "learned slot is not valid")
    `PLTA_ASSERT_SAME(a_idle_no_check, state_reg == S_IDLE, !chk_vld_reg, "compare stage busy while idle")

endmodule

// ===== rtl/plta_ram.sv =====
module plta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/plta_cmp.sv =====
module plta_cmp
    import plta_pkg::*;
#(
    parameter int KEY_BITS = 64
) (
    input  logic [KEY_BITS-1:0]  item_key,
    input  logic [KEY_BITS-1:0]  entry_key,
    input  logic [TIME_W-1:0]    now,
    input  logic [TIME_W-1:0]    seen,
    input  logic [TIMEOUT_W-1:0] timeout,
    output cmp_res_t             res
);

    logic [TIME_W-1:0] age;

    // Clamp age at zero when time runs backward, then test against the timeout
    always_comb
    begin
        age       = (now >= seen) ? (now - seen) : '0;
        res.match = (item_key == entry_key);
        res.stale = (age > TIME_W'(timeout));
    end

endmodule

// ===== sim/peer_table_checker.sv =====
module peer_table_checker
    import plta_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [TIMEOUT_W-1:0] cfg_wr_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 cmd,
    input  logic [63:0]          peer_key,
    input  logic [ADDR_W-1:0]    peer_addr,
    input  logic [63:0]          peer_name,
    input  logic [TIME_W-1:0]    now_seconds,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [STATUS_W-1:0]  status,
    input  logic [SLOT_W-1:0]    slot,
    input  logic [COUNT_W-1:0]   removed_count,
    input  logic [COUNT_W-1:0]   occupancy,
    output int                   mismatches,
    output int                   replies_due
);

    typedef struct packed {
        status_t              st;
        logic [SLOT_W-1:0]    slot_idx;
        logic [COUNT_W-1:0]   freed;
        logic [COUNT_W-1:0]   occ;
    } reply_t;

    // Shadow copy of the peer table
    logic                 slot_live [ENTRIES];
    logic [63:0]          slot_key  [ENTRIES];
    logic [ADDR_W-1:0]    slot_addr [ENTRIES];
    logic [63:0]          slot_name [ENTRIES];
    logic [TIME_W-1:0]    slot_seen [ENTRIES];
    int                   live_count;
    logic [TIMEOUT_W-1:0] aging_limit;
    reply_t               replies_q [$];

    // Apply one command beat to the shadow table and return the reply it earns
    function automatic reply_t apply_beat(
        logic              c,
        logic [63:0]       key,
        logic [ADDR_W-1:0] addr,
        logic [63:0]       name,
        logic [TIME_W-1:0] now
    );
        reply_t            r;
        int                hit;
        int                vacant;
        int                freed;
        logic [TIME_W-1:0] age;
        r.st       = STAT_SWEEP;
        r.slot_idx = '0;
        r.freed    = '0;
        if (c == CMD_LEARN)
        begin
            hit    = -1;
            vacant = -1;
            // first live match wins, lowest empty slot is the insert target
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (slot_live[i])
                begin
                    if (hit < 0 && slot_key[i] == key)
                        hit = i;
                end
                else if (vacant < 0)
                begin
                    vacant = i;
                end
            end
            if (hit >= 0)
            begin
                slot_seen[hit] = now;
                slot_addr[hit] = addr;
                slot_name[hit] = name;
                r.st           = STAT_REFRESH;
                r.slot_idx     = hit[SLOT_W-1:0];
            end
            else if (vacant >= 0)
            begin
                slot_live[vacant] = 1'b1;
                slot_key[vacant]  = key;
                slot_addr[vacant] = addr;
                slot_name[vacant] = name;
                slot_seen[vacant] = now;
                live_count++;
                r.st              = STAT_INSERT;
                r.slot_idx        = vacant[SLOT_W-1:0];
            end
            else
            begin
                r.st = STAT_FULL;
            end
        end
        else
        begin
            freed = 0;
            // age out entries; a stamp later than now counts as age zero
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (slot_live[i])
                begin
                    age = (now >= slot_seen[i]) ? now - slot_seen[i] : '0;
                    if (age > aging_limit)
                    begin
                        slot_live[i] = 1'b0;
                        freed++;
                    end
                end
            end
            live_count -= freed;
            r.freed     = freed[COUNT_W-1:0];
        end
        r.occ = live_count[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                slot_live[i] = 1'b0;
            live_count  = 0;
            aging_limit = TIMEOUT_RESET;
            replies_q.delete();
            replies_due = 0;
            mismatches  = 0;
        end
        else
        begin
            // compare a result beat against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (replies_q.size() == 0)
                begin
                    mismatches++;
                    $error("result beat with no prediction pending: status %0d slot %0d",
                           status, slot);
                end
                else
                begin
                    want = replies_q.pop_front();
                    if (status !== want.st)
                    begin
                        mismatches++;
                        $error("status: expected %0d, got %0d", want.st, status);
                    end
                    if (slot !== want.slot_idx)
                    begin
                        mismatches++;
                        $error("slot: expected %0d, got %0d", want.slot_idx, slot);
                    end
                    if (removed_count !== want.freed)
                    begin
                        mismatches++;
                        $error("removed_count: expected %0d, got %0d",
                               want.freed, removed_count);
                    end
                    if (occupancy !== want.occ)
                    begin
                        mismatches++;
                        $error("occupancy: expected %0d, got %0d", want.occ, occupancy);
                    end
                end
            end

            // track the timeout register
            if (cfg_wr_en)
                aging_limit = cfg_wr_data;

            // predict the reply for an accepted command beat
            if (in_valid && in_ready)
                replies_q.push_back(apply_beat(cmd, peer_key, peer_addr, peer_name,
                                               now_seconds));

            replies_due = replies_q.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    import plta_pkg::*;

    localparam int ENTRIES        = 16;
    localparam int SETTLE_CYCLES  = ENTRIES + 3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int KEY_POOL       = 20;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [TIMEOUT_W-1:0] cfg_wr_data = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic                 cmd         = CMD_LEARN;
    logic [63:0]          peer_key    = '0;
    logic [ADDR_W-1:0]    peer_addr   = '0;
    logic [63:0]          peer_name   = '0;
    logic [TIME_W-1:0]    now_seconds = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    slot;
    logic [COUNT_W-1:0]   removed_count;
    logic [COUNT_W-1:0]   occupancy;

    int                   mismatches;
    int                   replies_due;
    logic                 in_taken      = 1'b0;
    int                   send_idle_pct = 20;
    int                   recv_idle_pct = 54;

    peer_learning_table_with_aging #(.ENTRIES(ENTRIES)) dut (.*);

    peer_table_checker #(.ENTRIES(ENTRIES)) u_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Flag the input beat taken at the last rising edge
    always @(posedge clk)
        in_taken <= in_valid && in_ready;

    // Stall the result channel at random
    always @(negedge clk)
        out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);

    // Abort when no beat moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Present one command beat and hold it until taken; call at a falling edge
    task automatic send_beat(
        logic              c,
        logic [63:0]       key,
        logic [ADDR_W-1:0] addr,
        logic [63:0]       name,
        logic [TIME_W-1:0] now
    );
        if ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99, 0) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        peer_key    <= key;
        peer_addr   <= addr;
        peer_name   <= name;
        now_seconds <= now;
        do
            @(negedge clk);
        while (!in_taken);
    endtask

    // Drop valid, wait out every pending reply, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (replies_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_timeout(logic [TIMEOUT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Learn traffic over a small key pool with a drifting clock and some sweeps
    task automatic run_random(int n_items, int step_max, logic [TIME_W-1:0] start_time);
        logic [63:0]       key_pool [KEY_POOL];
        logic [TIME_W-1:0] clock_now;
        logic [63:0]       key;
        int                pick;
        clock_now = start_time;
        foreach (key_pool[i])
            key_pool[i] = {$urandom, $urandom};
        for (int n = 0; n < n_items; n++)
        begin
            pick      = $urandom_range(99, 0);
            clock_now = clock_now + $urandom_range(step_max, 0);
            // step the clock backward now and then, or jump anywhere
            if (pick < 3)
                clock_now = clock_now - $urandom_range(4 * step_max + 4, 1);
            else if (pick < 5)
                clock_now = $urandom;
            if ($urandom_range(9, 0) == 0)
                key = {$urandom, $urandom};
            else
                key = key_pool[$urandom_range(KEY_POOL - 1, 0)];
            if ($urandom_range(99, 0) < 15)
                send_beat(CMD_SWEEP, {$urandom, $urandom}, $urandom, {$urandom, $urandom},
                          clock_now);
            else
                send_beat(CMD_LEARN, key, $urandom, {$urandom, $urandom}, clock_now);
        end
        drain();
    endtask

    initial
    begin
        logic [TIMEOUT_W-1:0] tmo;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty sweep, extreme fields, refresh, fill, drop, aging edges
        set_idling(20, 54);
        send_beat(CMD_SWEEP, '0, '0, '0, '0);
        send_beat(CMD_LEARN, '0, '0, '0, 32'd100);
        send_beat(CMD_LEARN, '1, '1, '1, '1);
        send_beat(CMD_LEARN, '0, 32'hC0A8_0001, 64'h0000_6F6C_6C65_6800, 32'd110);
        for (int k = 1; k <= 14; k++)
            send_beat(CMD_LEARN, 64'(k), $urandom, {$urandom, $urandom}, 32'd120);
        send_beat(CMD_LEARN, 64'hDEAD_BEEF, $urandom, {$urandom, $urandom}, 32'd125);
        // age exactly at the timeout is kept, one past it is freed
        send_beat(CMD_SWEEP, '1, '1, '1, 32'd150);
        send_beat(CMD_SWEEP, '0, '0, '0, 32'd151);
        send_beat(CMD_LEARN, 64'd5, $urandom, {$urandom, $urandom}, 32'd152);
        drain();

        // random phases across timeout settings and idling regimes
        write_timeout(16'd0);
        run_random(270, 2, $urandom);
        write_timeout(16'hFFFF);
        run_random(270, 4098, 32'hFFFF_8000);

        set_idling(54, 20);
        write_timeout(16'd30);
        run_random(270, 4, $urandom);
        tmo = $urandom_range(65535, 0);
        write_timeout(tmo);
        run_random(270, tmo / 16 + 2, $urandom);

        set_idling(0, 0);
        write_timeout(16'd1);
        run_random(260, 2, $urandom);
        tmo = $urandom_range(200, 2);
        write_timeout(tmo);
        run_random(260, tmo / 16 + 2, $urandom);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
